FILE: src/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared constants, command codes and the result word type of the
// turtle plotter grid.
// ----------------------------------------------------------------------------
`default_nettype none

package tpg_pkg;

  localparam int GRID_SIZE_DEF = 32;
  localparam int MAX_SIDE      = 32;
  localparam int MIN_SIDE      = 2;

  localparam int REQ_W   = 3;
  localparam int STEP_W  = 8;
  localparam int ROW_W   = 32;
  localparam int IDX_W   = 5;
  localparam int HEAD_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PEN_UP     = 3'd0,
    REQ_PEN_DOWN   = 3'd1,
    REQ_TURN_RIGHT = 3'd2,
    REQ_TURN_LEFT  = 3'd3,
    REQ_MOVE       = 3'd4,
    REQ_DUMP       = 3'd5
  } req_t;

  typedef enum logic [HEAD_W-1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_bits;
    logic [IDX_W-1:0]  row_number;
    logic [IDX_W-1:0]  pos_row;
    logic [IDX_W-1:0]  pos_col;
    logic [HEAD_W-1:0] heading;
    logic              pen_is_down;
    logic              last;
  } result_t;

  // Side of the grid actually built: the requested size held to 2..32.
  function automatic int eff_size(input int size);
    int s;
    s = size;
    if (s < MIN_SIDE) s = MIN_SIDE;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/tpg_ram.sv
// ----------------------------------------------------------------------------
// tpg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tpg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/tpg_ctrl.sv
// ----------------------------------------------------------------------------
// tpg_ctrl
// Command sequencer: holds the turtle state, runs read-modify-write steps
// on the grid memory and walks the rows for a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module tpg_ctrl #(
  parameter int GRID_SIZE = tpg_pkg::GRID_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire logic [tpg_pkg::REQ_W-1:0]   cmd_req,
  input  wire logic [tpg_pkg::STEP_W-1:0]  cmd_steps,
  input  wire logic                        res_free,
  output logic                             res_load,
  output tpg_pkg::result_t                 res
);

  localparam int EFF = tpg_pkg::eff_size(GRID_SIZE);
  localparam int AW  = $clog2(EFF);
  localparam logic [tpg_pkg::IDX_W-1:0] EDGE = tpg_pkg::IDX_W'(EFF - 1);
  localparam logic [EFF-1:0] ONE = EFF'(1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_MOVE_RD  = 6'b000010,
    ST_MOVE_WR  = 6'b000100,
    ST_DUMP_RD  = 6'b001000,
    ST_DUMP_OUT = 6'b010000,
    ST_STATUS   = 6'b100000
  } state_t;

  state_t                          state, state_next;
  logic [tpg_pkg::IDX_W-1:0]       cur_row, cur_col;
  logic [tpg_pkg::IDX_W-1:0]       adv_row, adv_col;
  logic [tpg_pkg::HEAD_W-1:0]      cur_heading;
  logic                            pen_state;
  logic [tpg_pkg::STEP_W-1:0]      step_cnt;
  logic [tpg_pkg::IDX_W-1:0]       dump_row;
  logic [EFF-1:0]                  row_valid;
  logic                            accept;
  logic                            step_done;
  logic                            dump_last;

  logic                            wr_en, rd_en;
  logic [AW-1:0]                   wr_addr, rd_addr;
  logic [AW-1:0]                   rd_addr_q;
  logic [EFF-1:0]                  wr_data, rd_data, row_word;

  tpg_ram #(
    .WIDTH (EFF),
    .DEPTH (EFF)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign step_done = (step_cnt == tpg_pkg::STEP_W'(1));

  // Rows never written read as cleared.
  assign row_word = rd_data & {EFF{row_valid[rd_addr_q]}};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
  end

  // One step forward, stopping at the edge.
  always_comb begin
    adv_row = cur_row;
    adv_col = cur_col;
    case (cur_heading)
      tpg_pkg::HEAD_RIGHT: if (cur_col < EDGE) adv_col = cur_col + 1'b1;
      tpg_pkg::HEAD_DOWN:  if (cur_row < EDGE) adv_row = cur_row + 1'b1;
      tpg_pkg::HEAD_LEFT:  if (cur_col != '0)  adv_col = cur_col - 1'b1;
      default:             if (cur_row != '0)  adv_row = cur_row - 1'b1;
    endcase
  end

  assign dump_last = (dump_row == EDGE);

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = cur_row[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = cur_row[AW-1:0];
    wr_data    = row_word | (ONE << cur_col[AW-1:0]);
    res_load   = 1'b0;
    res        = '0;
    res.pos_row     = cur_row;
    res.pos_col     = cur_col;
    res.heading     = cur_heading;
    res.pen_is_down = pen_state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_req)
            tpg_pkg::REQ_MOVE: begin
              state_next = (cmd_steps == '0) ? ST_STATUS : ST_MOVE_RD;
            end
            tpg_pkg::REQ_DUMP: state_next = ST_DUMP_RD;
            default:           state_next = ST_STATUS;
          endcase
        end
      end
      ST_MOVE_RD: begin
        if (pen_state) begin
          rd_en      = 1'b1;
          state_next = ST_MOVE_WR;
        end else if (step_done) begin
          state_next = ST_STATUS;
        end
      end
      ST_MOVE_WR: begin
        wr_en      = 1'b1;
        state_next = step_done ? ST_STATUS : ST_MOVE_RD;
      end
      ST_DUMP_RD: begin
        rd_en      = 1'b1;
        rd_addr    = dump_row[AW-1:0];
        state_next = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        res.row_bits   = tpg_pkg::ROW_W'(row_word);
        res.row_number = dump_row;
        res.last       = dump_last;
        if (res_free) begin
          res_load   = 1'b1;
          state_next = dump_last ? ST_IDLE : ST_DUMP_RD;
        end
      end
      ST_STATUS: begin
        res.last = 1'b1;
        if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_row     <= '0;
      cur_col     <= '0;
      cur_heading <= tpg_pkg::HEAD_RIGHT;
      pen_state   <= 1'b0;
      row_valid   <= '0;
      step_cnt    <= '0;
      dump_row    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step_cnt <= cmd_steps;
        dump_row <= '0;
        case (cmd_req)
          tpg_pkg::REQ_PEN_UP:     pen_state   <= 1'b0;
          tpg_pkg::REQ_PEN_DOWN:   pen_state   <= 1'b1;
          tpg_pkg::REQ_TURN_RIGHT: cur_heading <= cur_heading + 2'd1;
          tpg_pkg::REQ_TURN_LEFT:  cur_heading <= cur_heading - 2'd1;
          default: ;
        endcase
      end
      // Advance once per step: after the write-back, or at once with pen up.
      if ((state == ST_MOVE_RD && !pen_state) || state == ST_MOVE_WR) begin
        cur_row  <= adv_row;
        cur_col  <= adv_col;
        step_cnt <= step_cnt - 1'b1;
      end
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (state == ST_DUMP_OUT && res_free) begin
        dump_row <= dump_row + 1'b1;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res_free)
    else $error("result loaded into a busy output register");

  a_write_pen_down: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> pen_state)
    else $error("grid written with pen up");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    cur_row <= EDGE && cur_col <= EDGE)
    else $error("turtle left the grid");

  a_wr_follows_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE_WR) |-> $past(rd_en) && $past(rd_addr) == cur_row[AW-1:0])
    else $error("write-back without a read of the same row");

  a_dump_last_row: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.last && state == ST_DUMP_OUT) |=> state == ST_IDLE)
    else $error("dump did not end after its last row");

endmodule

`default_nettype wire

FILE: src/tpg_outreg.sv
// ----------------------------------------------------------------------------
// tpg_outreg
// Output holding register: keeps one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tpg_outreg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire tpg_pkg::result_t din,
  output logic                  free,
  output logic                  valid,
  input  wire logic             ready,
  output tpg_pkg::result_t      dout
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> valid && $stable(dout))
    else $error("held result word changed before it was taken");

endmodule

`default_nettype wire

FILE: src/turtle_plotter_grid.sv
// ----------------------------------------------------------------------------
// turtle_plotter_grid
// Turtle command engine over a square bit grid kept in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  dir  bits  contents (low bit first)
//  s_*      in   16    req_type[2:0], step_count[10:3], zero pad
//  m_*      out  56    row_bits, row_number, pos_row, pos_col, heading,
//                      pen_is_down, zero pad; tlast = last of command
//
// Pen, turn and unknown commands: the accept leads to the status state, which
// loads the status word into the output register and returns to idle.
// Move: with pen up a step only advances the turtle; with pen down each step
// reads the row, then writes it back with the pen bit set; a status word
// follows. Dump: for each row a RAM read, then an output load, one row per
// grid side.
// Reset clears the per-row valid flags; no clearing pass is run.
// A stalled sink holds the sequencer at its next output load.
// ----------------------------------------------------------------------------
`default_nettype none

module turtle_plotter_grid #(
  parameter int GRID_SIZE = tpg_pkg::GRID_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // req_type, step_count
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // row_bits, row_number, pos_row, pos_col,
                                      // heading, pen_is_down
  output logic             m_tlast
);

  logic             res_free, res_load;
  tpg_pkg::result_t res, res_q;

  tpg_ctrl #(
    .GRID_SIZE (GRID_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd_req   (s_tdata[2:0]),
    .cmd_steps (s_tdata[10:3]),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res)
  );

  tpg_outreg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_load),
    .din   (res),
    .free  (res_free),
    .valid (m_tvalid),
    .ready (m_tready),
    .dout  (res_q)
  );

  assign m_tdata = {6'b0, res_q.pen_is_down, res_q.heading, res_q.pos_col,
                    res_q.pos_row, res_q.row_number, res_q.row_bits};
  assign m_tlast = res_q.last;

endmodule

`default_nettype wire
